FILE: sv/enst_pkg.sv
// Package: widths, class codes and register indexes for the event noise signal tagger.
package enst_pkg;
    localparam int MAX_SIGNALS = 64;
    localparam int TIME_BITS   = 24;
    localparam int IDX_BITS    = $clog2(MAX_SIGNALS);
    localparam int CNT_BITS    = $clog2(MAX_SIGNALS + 1);

    localparam logic [1:0] CLS_NEUTRAL = 2'd0;
    localparam logic [1:0] CLS_LOW     = 2'd1;
    localparam logic [1:0] CLS_REAL    = 2'd2;
    localparam logic [1:0] CLS_SUSP    = 2'd3;

    localparam logic [1:0] REG_ENERGY_CUT = 2'd0;
    localparam logic [1:0] REG_CHI_CUT    = 2'd1;
    localparam logic [1:0] REG_MULT_CUT   = 2'd2;
    localparam logic [1:0] REG_WINDOW     = 2'd3;

    localparam logic [1:0] ST_CLEAN   = 2'd0;
    localparam logic [1:0] ST_KEPT    = 2'd1;
    localparam logic [1:0] ST_PARTIAL = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // One stored signal: time, class and noise mark
    typedef struct packed {
        logic [TIME_BITS-1:0] t;
        logic [1:0]           cls;
        logic                 mark;
    } entry_t;
endpackage

FILE: sv/event_noise_signal_tagger_unit.sv
// Top level: signal store, pairwise coincidence sequencer and result stream.
//
// Signals are loaded at one word per cycle; loading a signal also clears its noise
// mark, which sits beside time and class in the signal store. The word with
// last_signal set starts the event scan: each stored signal i is fetched and, if
// suspicious, the store is swept over all n entries (a blocking pass looking for
// real signals in the window) and, if the suspicious signal is unblocked, swept
// again (a marking pass that writes marks back), one memory read per cycle. In the
// result phase each result word takes one store read and one output load, and the
// output waits while the receiver stalls; the block then returns to loading. The
// sweeps are set by the single read port of the signal store. Input is not accepted
// while an event is scanned or emitted.
module event_noise_signal_tagger_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // energy[15:0], chi_square[31:16], signal_time[55:32]
    input  logic        s_axis_tlast,   // last_signal
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // signal_index[5:0], remove[6], event_status[8:7],
                                        // remaining_count[15:9]
    output logic        m_axis_tlast,   // last_result
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import enst_pkg::*;

    localparam logic [2:0] S_LOAD = 3'd0, S_SCAN = 3'd1, S_WAIT = 3'd2,
                           S_MARK = 3'd3, S_NEXT = 3'd4, S_EMIT = 3'd5,
                           S_OUT  = 3'd6;

    logic signed [15:0]   ecut_reg;
    logic [15:0]          ccut_reg;
    logic [6:0]           mcut_reg;
    logic [23:0]          win_reg;

    entry_t               mem [MAX_SIGNALS];
    entry_t               rd_reg;
    logic [IDX_BITS-1:0]  rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_addr;
    entry_t               wr_data;

    logic [2:0]           st_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  i_reg, j_reg;   // sweep counters
    logic                 pass_reg;       // 0 blocking pass, 1 marking pass
    logic                 vld_reg;        // rd_reg holds entry j_reg-1
    logic                 blk_reg, any_reg;
    entry_t               cur_reg;        // entry i
    logic [CNT_BITS-1:0]  nmark_reg;
    logic [CNT_BITS-1:0]  o_reg;
    logic                 ovld_reg;
    logic [15:0]          odata_reg;
    logic                 olast_reg;

    logic signed [15:0] e_in;
    logic [15:0]        chi_in;
    logic [1:0]         cls_in;
    logic [TIME_BITS-1:0] dt;
    logic               near;
    logic [CNT_BITS-1:0] j_prev;
    logic               mark_hit;
    logic               removing;
    logic [CNT_BITS-1:0] remaining;
    logic [1:0]         status;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign e_in   = s_axis_tdata[15:0];
    assign chi_in = s_axis_tdata[31:16];
    assign s_axis_tready = (st_reg == S_LOAD);
    assign out_free = !ovld_reg || m_axis_tready;

    // Classify incoming signal
    always_comb
    begin
        if (e_in > ecut_reg)
            cls_in = CLS_REAL;
        else if (e_in < ecut_reg)
            cls_in = (chi_in > ccut_reg) ? CLS_SUSP : CLS_LOW;
        else
            cls_in = CLS_NEUTRAL;
    end

    // Time coincidence of the entry read back against entry i
    always_comb
    begin
        dt = (rd_reg.t > cur_reg.t) ? rd_reg.t - cur_reg.t : cur_reg.t - rd_reg.t;
        near = dt < win_reg;
    end

    // Mark a low-energy entry in the window that is not yet marked
    assign j_prev   = j_reg - 1'b1;
    assign mark_hit = (st_reg == S_MARK) && pass_reg && vld_reg && near &&
                      (rd_reg.cls == CLS_LOW || rd_reg.cls == CLS_SUSP) && !rd_reg.mark;

    assign removing  = nmark_reg > mcut_reg;
    assign remaining = removing ? cnt_reg - nmark_reg : cnt_reg;
    always_comb
    begin
        if (removing)
            status = (remaining == '0) ? ST_FULL : ST_PARTIAL;
        else
            status = any_reg ? ST_KEPT : ST_CLEAN;
    end

    // Memory port control
    always_comb
    begin
        wr_en        = s_axis_tvalid && s_axis_tready && (cnt_reg < CNT_BITS'(MAX_SIGNALS));
        wr_addr      = cnt_reg[IDX_BITS-1:0];
        wr_data.t    = s_axis_tdata[32 +: TIME_BITS];
        wr_data.cls  = cls_in;
        wr_data.mark = 1'b0;
        if (mark_hit)
        begin
            wr_en        = 1'b1;
            wr_addr      = j_prev[IDX_BITS-1:0];
            wr_data      = rd_reg;
            wr_data.mark = 1'b1;
        end
        rd_en   = 1'b0;
        rd_addr = j_reg[IDX_BITS-1:0];
        if ((st_reg == S_SCAN || st_reg == S_MARK) && j_reg < cnt_reg)
            rd_en = 1'b1;
        if (st_reg == S_NEXT)
        begin
            rd_en   = 1'b1;
            rd_addr = i_reg[IDX_BITS-1:0];
        end
        if (st_reg == S_EMIT && o_reg < cnt_reg)
        begin
            rd_en   = 1'b1;
            rd_addr = o_reg[IDX_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecut_reg <= 16'sd100;
            ccut_reg <= 16'd512;
            mcut_reg <= 7'd0;
            win_reg  <= 24'd40000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ENERGY_CUT: ecut_reg <= cfg_data[15:0];
                REG_CHI_CUT:    ccut_reg <= cfg_data[15:0];
                REG_MULT_CUT:   mcut_reg <= cfg_data[6:0];
                REG_WINDOW:     win_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Sequencer: load, scan each i over all j, emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_LOAD; cnt_reg <= '0; i_reg <= '0; j_reg <= '0;
            pass_reg <= 1'b0; vld_reg <= 1'b0; blk_reg <= 1'b0; any_reg <= 1'b0;
            nmark_reg <= '0; o_reg <= '0; ovld_reg <= 1'b0;
            cur_reg <= '0; odata_reg <= '0; olast_reg <= 1'b0;
        end
        else
        begin
            if (ovld_reg && m_axis_tready && st_reg != S_OUT)
                ovld_reg <= 1'b0;
            case (st_reg)
                S_LOAD:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (wr_en)
                            cnt_reg <= cnt_reg + 1'b1;
                        if (s_axis_tlast)
                        begin
                            i_reg <= '0;
                            st_reg <= S_NEXT;
                        end
                    end
                end
                S_NEXT:
                begin
                    // fetch entry i, or go to the result phase after the last entry
                    if (i_reg >= cnt_reg)
                    begin
                        o_reg <= '0;
                        st_reg <= S_EMIT;
                    end
                    else
                        st_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    cur_reg <= rd_reg;
                    j_reg <= '0; vld_reg <= 1'b0; blk_reg <= 1'b0; pass_reg <= 1'b0;
                    if (rd_reg.cls == CLS_SUSP)
                    begin
                        any_reg <= 1'b1;
                        st_reg <= S_SCAN;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        st_reg <= S_NEXT;
                    end
                end
                S_SCAN, S_MARK:
                begin
                    if (vld_reg)
                    begin
                        if (!pass_reg && rd_reg.cls == CLS_REAL && near)
                            blk_reg <= 1'b1;
                        if (mark_hit)
                            nmark_reg <= nmark_reg + 1'b1;
                    end
                    vld_reg <= (j_reg < cnt_reg);
                    if (j_reg < cnt_reg)
                        j_reg <= j_reg + 1'b1;
                    else
                    begin
                        j_reg <= '0;
                        if (!pass_reg && !(blk_reg || (vld_reg && rd_reg.cls == CLS_REAL
                            && near)))
                        begin
                            pass_reg <= 1'b1;
                            st_reg <= S_MARK;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            st_reg <= S_NEXT;
                        end
                    end
                end
                S_EMIT:
                begin
                    // read entry o, or close the event
                    if (o_reg < cnt_reg)
                        st_reg <= S_OUT;
                    else
                    begin
                        cnt_reg <= '0; nmark_reg <= '0;
                        any_reg <= 1'b0;
                        st_reg <= S_LOAD;
                    end
                end
                S_OUT:
                begin
                    // hold the entry until the output register frees up
                    if (out_free)
                    begin
                        ovld_reg  <= 1'b1;
                        odata_reg <= {7'(remaining), status, removing && rd_reg.mark,
                                      6'(o_reg)};
                        olast_reg <= (o_reg + 1'b1 == cnt_reg);
                        o_reg <= o_reg + 1'b1;
                        st_reg <= S_EMIT;
                    end
                end
                default: st_reg <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;
endmodule

FILE: tb/event_noise_signal_tagger_unit_tb.sv
// Testbench for the event noise signal tagger: directed and random events, scoreboard check.
module event_noise_signal_tagger_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import enst_pkg::*;

    // Expected result word of one stored signal
    typedef struct {
        logic [5:0] index;
        logic       remove;
        logic [1:0] status;
        logic [6:0] remaining;
        logic       last;
    } tag_result_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Tagging predictor and queue of expected result words
    class tag_scoreboard;
        logic signed [15:0] energy_cut = 16'sd100;
        logic [15:0]        chi_cut = 16'd512;
        logic [6:0]         mult_cut = 7'd0;
        logic [23:0]        window = 24'd40000;
        logic [23:0]        times [MAX_SIGNALS];
        logic [1:0]         classes [MAX_SIGNALS];
        int                 count = 0;
        tag_result_t        pending [$];

        function void set_reg(logic [1:0] idx, logic [23:0] val);
            case (idx)
                REG_ENERGY_CUT: energy_cut = val[15:0];
                REG_CHI_CUT:    chi_cut = val[15:0];
                REG_MULT_CUT:   mult_cut = val[6:0];
                default:        window = val;
            endcase
        endfunction

        function bit near(logic [23:0] a, logic [23:0] b);
            logic [23:0] d;
            d = (a > b) ? a - b : b - a;
            return d < window;
        endfunction

        function void note_signal(logic signed [15:0] e, logic [15:0] chi, logic [23:0] t,
                                  logic lst);
            bit marks [MAX_SIGNALS];
            bit any_susp, blocked, removing;
            int marked, remaining;
            logic [1:0] status;
            tag_result_t r;
            if (count < MAX_SIGNALS) begin
                if (e > energy_cut) classes[count] = CLS_REAL;
                else if (e < energy_cut) classes[count] = (chi > chi_cut) ? CLS_SUSP : CLS_LOW;
                else classes[count] = CLS_NEUTRAL;
                times[count] = t;
                count++;
            end
            if (!lst) return;
            any_susp = 0;
            marked = 0;
            foreach (marks[k]) marks[k] = 0;
            for (int i = 0; i < count; i++) begin
                if (classes[i] != CLS_SUSP) continue;
                any_susp = 1;
                blocked = 0;
                for (int j = 0; j < count; j++)
                    if (classes[j] == CLS_REAL && near(times[j], times[i])) blocked = 1;
                if (blocked) continue;
                for (int j = 0; j < count; j++)
                    if ((classes[j] == CLS_LOW || classes[j] == CLS_SUSP)
                        && near(times[j], times[i])) marks[j] = 1;
            end
            for (int i = 0; i < count; i++) marked += marks[i];
            removing = marked > mult_cut;
            if (removing) begin
                remaining = count - marked;
                status = (remaining == 0) ? ST_FULL : ST_PARTIAL;
            end else begin
                remaining = count;
                status = any_susp ? ST_KEPT : ST_CLEAN;
            end
            for (int i = 0; i < count; i++) begin
                r.index = i[5:0];
                r.remove = removing && marks[i];
                r.status = status;
                r.remaining = remaining[6:0];
                r.last = (i + 1 == count);
                pending = {pending, r};
            end
            count = 0;
        endfunction

        task check_word(logic [15:0] d, logic lst);
            tag_result_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", d, 0);
                return;
            end
            w = pending.pop_front();
            if (d[5:0] != w.index) report_mismatch("signal_index", d[5:0], w.index);
            if (d[6] != w.remove) report_mismatch("remove", d[6], w.remove);
            if (d[8:7] != w.status) report_mismatch("event_status", d[8:7], w.status);
            if (d[15:9] != w.remaining) report_mismatch("remaining_count", d[15:9], w.remaining);
            if (lst != w.last) report_mismatch("last_result", lst, w.last);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    tag_scoreboard sb = new();
    bit quiet = 0;      // no idling in the closing part
    bit hold_off = 0;   // long receiver stall requested

    event_noise_signal_tagger_unit uut (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial begin
        #40ms;
        $display("event_noise_signal_tagger_unit verification failed");
        $finish;
    end

    // Receiver: random ready bursts, optional long stall, check on accept
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (3000) @(negedge clk);
                hold_off = 0;
            end
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 14);
                m_axis_tready <= 0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready <= 1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);

    // Present one signal word and hold it until accepted; valid drops on the next idle
    task automatic send_signal(input logic signed [15:0] e, input logic [15:0] chi,
                               input logic [23:0] t, input logic lst);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {t, chi, e};
        s_axis_tlast <= lst;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_signal(e, chi, t, lst);
        @(negedge clk);
    endtask

    // Wait until every expected word is out, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    // Random event: mostly low-energy noise, with some real and cut-equal signals, clustered around a few centres
    task automatic random_event(input int len, input int ecut);
        logic [23:0] centre;
        logic signed [15:0] e;
        centre = 24'($urandom_range(0, 24'hFFFFFF));
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 5))
                0: e = 16'(ecut + int'($urandom_range(1, 300)));
                1: e = 16'(ecut);
                2: e = 16'($urandom);
                default: e = 16'(ecut - int'($urandom_range(1, 300)));
            endcase
            if ($urandom_range(0, 3) == 0) centre = 24'($urandom);
            send_signal(e, 16'($urandom_range(0, 3) ? $urandom_range(0, 1500) : $urandom),
                        24'(centre + $urandom_range(0, 60000)), i == len - 1);
        end
    endtask

    initial begin
        int items;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: defaults, cut equality, extremes, isolated noise
        send_signal(16'sd100, 16'd9000, 24'd0, 0);          // equals cut
        send_signal(16'sd5, 16'd513, 24'd10, 0);            // suspicious
        send_signal(16'sd4, 16'd512, 24'd39000, 0);         // low, at chi cut
        send_signal(-16'sd32768, 16'hFFFF, 24'hFFFFFF, 0);
        send_signal(16'sd32767, 16'd0, 24'hFFFF00, 1);      // real blocks far one
        send_signal(16'sd0, 16'd1000, 24'd500, 1);          // single: fully removed
        send_signal(16'sd0, 16'd1000, 24'd500, 0);
        send_signal(16'sd101, 16'd1000, 24'd40499, 1);      // real just inside window
        drain();

        // Store full: 66 signals, extra ones dropped, dropped last ends event
        for (int i = 0; i < 66; i++)
            send_signal(16'sd0, (i % 2) ? 16'd600 : 16'd100, 24'(i * 1000), i == 65);
        drain();

        // Extreme registers
        write_reg(REG_ENERGY_CUT, 24'h008000);
        write_reg(REG_CHI_CUT, 24'h00FFFF);
        write_reg(REG_MULT_CUT, 24'd64);
        write_reg(REG_WINDOW, 24'hFFFFFF);
        send_signal(-16'sd32768, 16'hFFFF, 24'd0, 0);
        send_signal(16'sd1, 16'hFFFF, 24'hFFFFFF, 1);
        drain();
        write_reg(REG_ENERGY_CUT, 24'h007FFF);
        write_reg(REG_CHI_CUT, 24'd0);
        write_reg(REG_MULT_CUT, 24'd0);
        write_reg(REG_WINDOW, 24'd0);
        send_signal(16'sd0, 16'd1, 24'd7, 0);
        send_signal(16'sd32767, 16'd1, 24'd7, 1);
        drain();

        // Random events over several settings; long receiver stall during the first
        items = 0;
        hold_off = 1;
        for (int phase = 0; phase < 4; phase++) begin
            int ecut;
            ecut = $urandom_range(0, 2) ? $urandom_range(0, 200) : $signed(16'($urandom));
            if (ecut > 32467) ecut = 32467;
            if (ecut < -32467) ecut = -32467;
            write_reg(REG_ENERGY_CUT, 24'(ecut));
            write_reg(REG_CHI_CUT, 24'($urandom_range(0, 1200)));
            write_reg(REG_MULT_CUT, 24'($urandom_range(0, 3) ? $urandom_range(0, 4)
                                                              : $urandom_range(0, 64)));
            write_reg(REG_WINDOW, 24'($urandom_range(0, 3) ? $urandom_range(1000, 50000)
                                                            : $urandom));
            if (phase == 3) quiet = 1;
            while (items < (phase + 1) * 38) begin
                int len;
                len = $urandom_range(0, 9) ? $urandom_range(1, 8) : $urandom_range(9, 20);
                random_event(len, ecut);
                items += len;
            end
            drain();
        end

        if (error_count == 0)
            $display("event_noise_signal_tagger_unit verification clean");
        else
            $display("event_noise_signal_tagger_unit verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
sv/enst_pkg.sv
sv/event_noise_signal_tagger_unit.sv
tb/event_noise_signal_tagger_unit_tb.sv
